FILE: rtl/rmt_pkg.sv
// ----------------------------------------------------------------------------
// Ranging measure table package
// Shared types and constants for the ranging measure table unit.
// ----------------------------------------------------------------------------
package rmt_pkg;

	localparam int ANCHOR_SLOTS = 7;
	localparam logic [15:0] BROADCAST_ADDR = 16'hFFFF;

	// Operation codes carried in the opcode field.
	typedef enum logic [2:0] {
		OP_ADD      = 3'd0,
		OP_FIND     = 3'd1,
		OP_DEL_TAG  = 3'd2,
		OP_DEL_LAST = 3'd3,
		OP_DEL_ALL  = 3'd4,
		OP_NEXT     = 3'd5,
		OP_REWIND   = 3'd6
	} rmt_op_t;

	// One table entry as kept in the entry memory.
	typedef struct packed {
		logic [15:0]                   tag;
		logic [2:0]                    acnt;
		logic [ANCHOR_SLOTS-1:0][15:0] anchors;
	} rmt_entry_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FIND_RD,
		ST_FIND_CMP,
		ST_DT_RD,
		ST_DT_CMP,
		ST_DT_CPRD,
		ST_DT_CPWR,
		ST_NEXT_OUT,
		ST_REPORT
	} rmt_state_t;

endpackage

FILE: rtl/ranging_measure_table_unit.sv
// ----------------------------------------------------------------------------
// Ranging measure table unit
// Keeps a packed table of ranging measurements (a tag and up to seven
// anchors per entry) and serves add, find, delete, next and rewind words.
// One input word is taken at a time and gives one result word. Find reads
// the entry memory one entry at a time through its single read port. Delete
// tag walks down from the last entry and moves the last entry into the place
// of each other entry that it deletes. The entry memory needs no clearing
// after reset, since only entries below the fill count are ever used.
// ----------------------------------------------------------------------------
module ranging_measure_table_unit
	import rmt_pkg::*;
#(
	parameter int TABLE_DEPTH = 64,
	parameter int POLL_LIMIT  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [15:0] tag_addr,
	input  logic [15:0] peer_addr,
	input  logic [15:0] count,
	input  logic [15:0] anchor_0,
	input  logic [15:0] anchor_1,
	input  logic [15:0] anchor_2,
	input  logic [15:0] anchor_3,
	input  logic [15:0] anchor_4,
	input  logic [15:0] anchor_5,
	input  logic [15:0] anchor_6,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ok,
	output logic [5:0]  entry_index,
	output logic [6:0]  entry_count,
	output logic [15:0] out_tag,
	output logic [2:0]  out_anchor_count,
	output logic [15:0] out_anchor_0,
	output logic [15:0] out_anchor_1,
	output logic [15:0] out_anchor_2,
	output logic [15:0] out_anchor_3,
	output logic [15:0] out_anchor_4,
	output logic [15:0] out_anchor_5,
	output logic [15:0] out_anchor_6
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = $bits(rmt_entry_t);

	rmt_state_t state_q, state_d;
	rmt_op_t    op_q;
	logic [15:0] a1_q, a2_q, cnt_q;
	logic [ANCHOR_SLOTS-1:0][15:0] anc_q;

	logic [CW-1:0] used_q, cursor_q, idx_q;
	logic          hit_q, out_valid_q;
	logic [CW-1:0] eidx_q;
	rmt_entry_t    ent_q;

	logic          ram_we;
	logic [IW-1:0] ram_waddr, ram_raddr;
	rmt_entry_t    ram_wdata, ram_rdata;
	logic          match_hit;
	logic          add_ok;
	logic          tag_hit;
	logic          last_is_idx;
	rmt_entry_t    add_entry;

	assign in_ready  = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;

	// Entry memory and the compare unit used by find.
	rmt_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	rmt_match u_match (
		.entry (ram_rdata),
		.addr_a(a1_q),
		.addr_b(a2_q),
		.hit   (match_hit)
	);

	// Add checks and the entry it writes; unused anchors are stored as zero.
	always_comb begin
		add_ok = (used_q < CW'(TABLE_DEPTH)) && (cnt_q != 16'd0) &&
			(cnt_q < 16'(POLL_LIMIT)) && (cnt_q <= 16'(ANCHOR_SLOTS)) &&
			(anc_q[0] != BROADCAST_ADDR);
		add_entry.tag  = a1_q;
		add_entry.acnt = cnt_q[2:0];
		for (int k = 0; k < ANCHOR_SLOTS; k++) begin
			add_entry.anchors[k] = (16'(k) < cnt_q) ? anc_q[k] : 16'd0;
		end
	end

	assign tag_hit     = (ram_rdata.tag == a1_q);
	assign last_is_idx = (idx_q == (used_q - CW'(1)));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (op_q)
					OP_FIND:    state_d = ST_FIND_RD;
					OP_DEL_TAG: state_d = (used_q == '0) ? ST_REPORT : ST_DT_RD;
					OP_NEXT:    state_d = (cursor_q < used_q) ? ST_NEXT_OUT : ST_REPORT;
					default:    state_d = ST_REPORT;
				endcase
			end
			ST_FIND_RD: begin
				state_d = (idx_q == used_q) ? ST_REPORT : ST_FIND_CMP;
			end
			ST_FIND_CMP: begin
				state_d = match_hit ? ST_REPORT : ST_FIND_RD;
			end
			ST_DT_RD: begin
				state_d = ST_DT_CMP;
			end
			ST_DT_CMP: begin
				if (tag_hit && !last_is_idx) begin
					state_d = ST_DT_CPRD;
				end else begin
					state_d = (idx_q == '0) ? ST_REPORT : ST_DT_RD;
				end
			end
			ST_DT_CPRD: begin
				state_d = ST_DT_CPWR;
			end
			ST_DT_CPWR: begin
				state_d = (idx_q == '0) ? ST_REPORT : ST_DT_RD;
			end
			ST_NEXT_OUT: begin
				state_d = ST_REPORT;
			end
			ST_REPORT: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory port controls.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[IW-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = idx_q[IW-1:0];
		case (state_q)
			ST_EXEC: begin
				if (op_q == OP_ADD && add_ok) begin
					ram_we    = 1'b1;
					ram_waddr = used_q[IW-1:0];
					ram_wdata = add_entry;
				end
				ram_raddr = cursor_q[IW-1:0];
			end
			ST_DT_CPRD: begin
				ram_raddr = used_q[IW-1:0];
			end
			ST_DT_CPWR: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequencer and table control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			cursor_q    <= '0;
			idx_q       <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) hit_q <= 1'b0;
				end
				ST_EXEC: begin
					case (op_q)
						OP_ADD: begin
							if (add_ok) begin
								used_q <= used_q + CW'(1);
								hit_q  <= 1'b1;
							end
						end
						OP_FIND: idx_q <= '0;
						OP_DEL_TAG: idx_q <= used_q - CW'(1);
						OP_DEL_LAST: begin
							if (cnt_q != 16'd0) begin
								used_q <= (cnt_q >= 16'(used_q)) ? '0 : used_q - cnt_q[CW-1:0];
							end
						end
						OP_DEL_ALL: begin
							used_q   <= '0;
							cursor_q <= '0;
						end
						OP_REWIND: cursor_q <= '0;
						default: begin
						end
					endcase
				end
				ST_FIND_CMP: begin
					if (match_hit) hit_q <= 1'b1;
					else idx_q <= idx_q + CW'(1);
				end
				ST_DT_CMP: begin
					if (tag_hit) begin
						used_q <= used_q - CW'(1);
						hit_q  <= 1'b1;
					end
					if (!(tag_hit && !last_is_idx) && idx_q != '0) idx_q <= idx_q - CW'(1);
				end
				ST_DT_CPWR: begin
					if (idx_q != '0) idx_q <= idx_q - CW'(1);
				end
				ST_NEXT_OUT: begin
					hit_q    <= 1'b1;
					cursor_q <= cursor_q + CW'(1);
				end
				ST_REPORT: begin
					out_valid_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Input capture and result entry registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && in_ready) begin
			op_q     <= rmt_op_t'(opcode);
			a1_q     <= tag_addr;
			a2_q     <= peer_addr;
			cnt_q    <= count;
			anc_q[0] <= anchor_0;
			anc_q[1] <= anchor_1;
			anc_q[2] <= anchor_2;
			anc_q[3] <= anchor_3;
			anc_q[4] <= anchor_4;
			anc_q[5] <= anchor_5;
			anc_q[6] <= anchor_6;
			ent_q    <= '0;
			eidx_q   <= '0;
		end else if (state_q == ST_FIND_CMP && match_hit) begin
			ent_q  <= ram_rdata;
			eidx_q <= idx_q;
		end else if (state_q == ST_NEXT_OUT) begin
			ent_q  <= ram_rdata;
			eidx_q <= cursor_q;
		end
	end

	// Result word.
	assign ok               = hit_q;
	assign entry_index      = 6'(eidx_q);
	assign entry_count      = 7'(used_q);
	assign out_tag          = ent_q.tag;
	assign out_anchor_count = ent_q.acnt;
	assign out_anchor_0     = ent_q.anchors[0];
	assign out_anchor_1     = ent_q.anchors[1];
	assign out_anchor_2     = ent_q.anchors[2];
	assign out_anchor_3     = ent_q.anchors[3];
	assign out_anchor_4     = ent_q.anchors[4];
	assign out_anchor_5     = ent_q.anchors[5];
	assign out_anchor_6     = ent_q.anchors[6];

	// The fill count never passes the table depth.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(TABLE_DEPTH))
		else $error("fill count above table depth");

	// A result word only appears after the report step.
	a_report: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_REPORT))
		else $error("result word without report step");

	// An accepted word starts execution on the next cycle.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_EXEC))
		else $error("accepted word did not start");

	// The read cursor only moves forward on a delivered entry.
	a_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(cursor_q > $past(cursor_q)) |-> $past(state_q == ST_NEXT_OUT))
		else $error("cursor advanced outside next");

endmodule

FILE: rtl/rmt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/rmt_match.sv
// ----------------------------------------------------------------------------
// Entry match unit
// Tells whether an entry pairs two device addresses in either role.
// ----------------------------------------------------------------------------
module rmt_match
	import rmt_pkg::*;
(
	input  rmt_entry_t  entry,
	input  logic [15:0] addr_a,
	input  logic [15:0] addr_b,
	output logic        hit
);

	logic has_a;
	logic has_b;

	// Only the first acnt anchors take part in the compare.
	always_comb begin
		has_a = 1'b0;
		has_b = 1'b0;
		for (int k = 0; k < ANCHOR_SLOTS; k++) begin
			if (3'(k) < entry.acnt) begin
				if (entry.anchors[k] == addr_a) has_a = 1'b1;
				if (entry.anchors[k] == addr_b) has_b = 1'b1;
			end
		end
		hit = ((entry.tag == addr_a) && has_b) || ((entry.tag == addr_b) && has_a);
	end

endmodule
